// File: src/mase_pkg.sv
// ============================================================================
// mase_pkg
// Shared types and constants for the multiaddr socket extractor.
// ============================================================================
package mase_pkg;

    localparam int LEN_BITS_DEFAULT = 16;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [63:0] CODE_IP4  = 64'd4;
    localparam logic [63:0] CODE_IP6  = 64'd41;
    localparam logic [63:0] CODE_TCP  = 64'd6;
    localparam logic [63:0] CODE_UDP  = 64'd273;

    localparam logic [4:0] IP4_BYTES  = 5'd4;
    localparam logic [4:0] IP6_BYTES  = 5'd16;
    localparam logic [4:0] PORT_BYTES = 5'd2;

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        transport;
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
    } out_t;

endpackage

// File: src/multiaddr_socket_extractor.sv
// ============================================================================
// multiaddr_socket_extractor
// Streaming parser that pulls an IP address and a transport port out of a
// binary multiaddr.
// ============================================================================
// Usage: one byte of the binary multiaddr arrives per transfer on the byte
// channel (byte_valid, byte_stall, byte_data), its last flag marking the
// final byte. Protocol codes are LEB128 varints; ip4/ip6 take their address
// bytes, tcp/udp their port, and any other code a varint length of skipped
// bytes. Once both an address and a port are held, one result with status
// found goes out on the socket channel (sock_valid, sock_stall, sock_data)
// and the rest of the bytes up to last are dropped. Otherwise one status
// result (malformed or not found) goes out at the last byte.
// Throughput: one byte per cycle while byte_stall is low. The result that a
// byte causes is registered in the result register, or in the skid register
// while sock_stall holds the result register. The two let a byte be taken
// while a result waits; byte_stall rises only when both are full. Reset
// clears the parse state and both output valid flags. After every last
// byte the parser returns to its reset state.
// ============================================================================
module multiaddr_socket_extractor #(
    parameter int LEN_BITS = mase_pkg::LEN_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  mase_pkg::in_t  byte_data,
    output logic           sock_valid,
    input  logic           sock_stall,
    output mase_pkg::out_t sock_data
);

    localparam logic [2:0] PH_CODE = 3'd0;
    localparam logic [2:0] PH_ADDR = 3'd1;
    localparam logic [2:0] PH_PORT = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [2:0] PH_ERR  = 3'd6;

    logic [2:0]          phase_reg,         phase_next,  phase_mid;
    logic [63:0]         varint_acc_reg,    varint_acc_next;
    logic [3:0]          varint_count_reg,  varint_count_next;
    logic [4:0]          field_count_reg,   field_count_next;
    logic [LEN_BITS-1:0] skip_left_reg,     skip_left_next;
    logic [63:0]         addr_hi_reg,       addr_hi_next;
    logic [63:0]         addr_lo_reg,       addr_lo_next;
    logic                addr_v6_reg,       addr_v6_next;
    logic [15:0]         port_reg,          port_next;
    logic                transport_reg,     transport_next;
    logic                have_ip_reg,       have_ip_next;
    logic                have_port_reg,     have_port_next;
    logic                error_seen_reg,    error_seen_next;

    logic                sock_valid_reg;
    mase_pkg::out_t      sock_data_reg;
    logic                skid_valid_reg;
    mase_pkg::out_t      skid_data_reg;

    logic                byte_take;
    logic                sock_take;
    logic                out_free;
    logic [7:0]          b;
    logic [5:0]          shift_amt;
    logic [63:0]         acc_sum;
    logic [3:0]          count_inc;
    logic [4:0]          field_dec;
    logic [LEN_BITS-1:0] skip_dec;
    logic                found;
    logic                res_fire;
    mase_pkg::out_t      res;

    assign byte_stall = skid_valid_reg;
    assign byte_take  = byte_valid && !skid_valid_reg;
    assign sock_valid = sock_valid_reg;
    assign sock_data  = sock_data_reg;
    assign sock_take  = sock_valid_reg && !sock_stall;
    assign out_free   = !sock_valid_reg || !sock_stall;

    assign b         = byte_data.byte_in;
    assign shift_amt = (6'(varint_count_reg) << 3) - 6'(varint_count_reg);
    assign acc_sum   = varint_acc_reg | ({56'd0, 1'b0, b[6:0]} << shift_amt);
    assign count_inc = varint_count_reg + 4'd1;
    assign field_dec = field_count_reg - 5'd1;
    assign skip_dec  = skip_left_reg - LEN_BITS'(1);

    always_comb
    begin
        phase_mid         = phase_reg;
        varint_acc_next   = varint_acc_reg;
        varint_count_next = varint_count_reg;
        field_count_next  = field_count_reg;
        skip_left_next    = skip_left_reg;
        addr_hi_next      = addr_hi_reg;
        addr_lo_next      = addr_lo_reg;
        addr_v6_next      = addr_v6_reg;
        port_next         = port_reg;
        transport_next    = transport_reg;
        have_ip_next      = have_ip_reg;
        have_port_next    = have_port_reg;
        error_seen_next   = error_seen_reg;

        unique case (phase_reg)
            PH_CODE, PH_LEN:
            begin
                varint_acc_next   = acc_sum;
                varint_count_next = count_inc;
                if (b[7])
                begin
                    if (count_inc >= mase_pkg::VARINT_MAX_BYTES)
                    begin
                        error_seen_next = 1'b1;
                        phase_mid       = PH_ERR;
                    end
                end
                else
                begin
                    varint_acc_next   = '0;
                    varint_count_next = '0;
                    if (phase_reg == PH_CODE)
                    begin
                        if (acc_sum == mase_pkg::CODE_IP4 || acc_sum == mase_pkg::CODE_IP6)
                        begin
                            addr_hi_next     = '0;
                            addr_lo_next     = '0;
                            addr_v6_next     = (acc_sum == mase_pkg::CODE_IP6);
                            field_count_next = (acc_sum == mase_pkg::CODE_IP6) ?
                                               mase_pkg::IP6_BYTES : mase_pkg::IP4_BYTES;
                            phase_mid        = PH_ADDR;
                        end
                        else if (acc_sum == mase_pkg::CODE_TCP || acc_sum == mase_pkg::CODE_UDP)
                        begin
                            transport_next   = (acc_sum == mase_pkg::CODE_TCP);
                            field_count_next = mase_pkg::PORT_BYTES;
                            phase_mid        = PH_PORT;
                        end
                        else
                        begin
                            phase_mid = PH_LEN;
                        end
                    end
                    else if (|acc_sum[63:LEN_BITS])
                    begin
                        error_seen_next = 1'b1;
                        phase_mid       = PH_ERR;
                    end
                    else if (acc_sum == 64'd0)
                    begin
                        phase_mid = PH_CODE;
                    end
                    else
                    begin
                        skip_left_next = acc_sum[LEN_BITS-1:0];
                        phase_mid      = PH_SKIP;
                    end
                end
            end
            PH_ADDR:
            begin
                addr_hi_next     = {addr_hi_reg[55:0], addr_lo_reg[63:56]};
                addr_lo_next     = {addr_lo_reg[55:0], b};
                field_count_next = field_dec;
                if (field_dec == 5'd0)
                begin
                    have_ip_next = 1'b1;
                    phase_mid    = PH_CODE;
                end
            end
            PH_PORT:
            begin
                port_next        = {port_reg[7:0], b};
                field_count_next = field_dec;
                if (field_dec == 5'd0)
                begin
                    have_port_next = 1'b1;
                    phase_mid      = PH_CODE;
                end
            end
            PH_SKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_mid = PH_CODE;
                end
            end
            default:
            begin
                phase_mid = phase_reg;
            end
        endcase

        found = (phase_mid == PH_CODE) && (varint_count_next == 4'd0) &&
                have_ip_next && have_port_next;

        res      = '0;
        res_fire = 1'b0;
        phase_next = found ? PH_DONE : phase_mid;

        if (found)
        begin
            res.status    = mase_pkg::STATUS_FOUND;
            res.transport = transport_next;
            res.is_ipv6   = addr_v6_next;
            res.addr_high = addr_hi_next;
            res.addr_low  = addr_lo_next;
            res.port      = port_next;
            res_fire      = 1'b1;
        end
        else if (byte_data.last && phase_mid != PH_DONE)
        begin
            res.status = (phase_mid == PH_CODE && varint_count_next == 4'd0 && !error_seen_next)
                         ? mase_pkg::STATUS_NOT_FOUND : mase_pkg::STATUS_MALFORMED;
            res_fire   = 1'b1;
        end

        if (byte_data.last)
        begin
            phase_next        = PH_CODE;
            varint_acc_next   = '0;
            varint_count_next = '0;
            field_count_next  = '0;
            skip_left_next    = '0;
            addr_hi_next      = '0;
            addr_lo_next      = '0;
            addr_v6_next      = 1'b0;
            port_next         = '0;
            transport_next    = 1'b0;
            have_ip_next      = 1'b0;
            have_port_next    = 1'b0;
            error_seen_next   = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_CODE;
            varint_acc_reg   <= '0;
            varint_count_reg <= '0;
            field_count_reg  <= '0;
            skip_left_reg    <= '0;
            addr_hi_reg      <= '0;
            addr_lo_reg      <= '0;
            addr_v6_reg      <= 1'b0;
            port_reg         <= '0;
            transport_reg    <= 1'b0;
            have_ip_reg      <= 1'b0;
            have_port_reg    <= 1'b0;
            error_seen_reg   <= 1'b0;
        end
        else if (byte_take)
        begin
            phase_reg        <= phase_next;
            varint_acc_reg   <= varint_acc_next;
            varint_count_reg <= varint_count_next;
            field_count_reg  <= field_count_next;
            skip_left_reg    <= skip_left_next;
            addr_hi_reg      <= addr_hi_next;
            addr_lo_reg      <= addr_lo_next;
            addr_v6_reg      <= addr_v6_next;
            port_reg         <= port_next;
            transport_reg    <= transport_next;
            have_ip_reg      <= have_ip_next;
            have_port_reg    <= have_port_next;
            error_seen_reg   <= error_seen_next;
        end
    end

    // result register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sock_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                sock_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (byte_take && res_fire)
        begin
            if (out_free)
            begin
                sock_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (sock_take)
        begin
            sock_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                sock_data_reg <= skid_data_reg;
            end
        end
        else if (byte_take && res_fire)
        begin
            if (out_free)
            begin
                sock_data_reg <= res;
            end
            else
            begin
                skid_data_reg <= res;
            end
        end
    end

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> sock_valid_reg)
        else $error("skid stage full while result register empty");

    a_done_has_both: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (have_ip_reg && have_port_reg))
        else $error("done phase without address and port");

    a_varint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CODE || phase_reg == PH_LEN) |->
        (varint_count_reg < mase_pkg::VARINT_MAX_BYTES))
        else $error("varint byte count past limit");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (sock_valid_reg && sock_data_reg.status != mase_pkg::STATUS_FOUND) |->
        (sock_data_reg.port == 16'd0 && sock_data_reg.addr_low == 64'd0 &&
         sock_data_reg.addr_high == 64'd0 && !sock_data_reg.is_ipv6 &&
         !sock_data_reg.transport))
        else $error("failure result carries socket fields");

endmodule
